[rtl/core/windowed_overlap_add_mixer_defines.svh]
// assertion macros used by the mixer sequencer rtl
// no dependencies; define ASSERT_OFF to drop every check
`ifndef WINDOWED_OVERLAP_ADD_MIXER_DEFINES_SVH
`define WINDOWED_OVERLAP_ADD_MIXER_DEFINES_SVH

`ifndef ASSERT_OFF

`define WOLA_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("wola assertion failed");

`define WOLA_ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("wola forbidden condition seen");

`else

`define WOLA_ASSERT(lbl, clk, rstn, prop)

`define WOLA_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

[rtl/core/wola_pkg.sv]
// types and constants for the windowed overlap-add mixer
// used by the controller, the datapath and the top level
package wola_pkg;

	localparam int LEN_W  = 10;
	localparam int GAIN_W = 16;
	localparam int MODE_W = 2;
	localparam int POS_W  = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [POS_W-1:0]  POS_MAX    = 11'd2047;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd32768;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RISE_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FALL_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIX_MODE    = 2'd3;

	// mix modes; the unused code behaves as both ramps
	localparam logic [MODE_W-1:0] MODE_BOTH_RAMPS = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FLAT_RISE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FLAT_FALL  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_LOAD,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic accept;
		logic mul_a;
		logic mul_b;
		logic load;
		logic div_step;
		logic fin_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} status_t;

endpackage

[rtl/core/wola_in_if.sv]
// input channel of the mixer: grain sample, base sample and restart flag
// depends on nothing; width follows the sample width parameter
interface wola_in_if #(
	parameter int SAMPLE_BITS = 16
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] grain_sample;
	logic signed [SAMPLE_BITS-1:0] base_sample;
	logic                          restart;

	modport source (output valid, grain_sample, base_sample, restart, input ready);
	modport sink (input valid, grain_sample, base_sample, restart, output ready);
endinterface

[rtl/core/wola_out_if.sv]
// output channel of the mixer: mixed sample and last flag
// depends on nothing; width follows the sample width parameter
interface wola_out_if #(
	parameter int SAMPLE_BITS = 16
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] mixed_sample;
	logic                          last;

	modport source (output valid, mixed_sample, last, input ready);
	modport sink (input valid, mixed_sample, last, output ready);
endinterface

[rtl/core/wola_dp.sv]
// datapath of the mixer: config registers, position counter, two multiply
// stages, a restoring divider and the saturating output register; uses wola_pkg
module wola_dp #(
	parameter int FRAME_LENGTH = 1024,
	parameter int SAMPLE_BITS  = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [wola_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [wola_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic signed [SAMPLE_BITS-1:0]         grain_sample,
	input  logic signed [SAMPLE_BITS-1:0]         base_sample,
	input  logic                                  restart,
	input  wola_pkg::cmd_t                        cmd,
	output wola_pkg::status_t                     status,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output logic signed [SAMPLE_BITS-1:0]         mixed_sample,
	output logic                                  last
);

	localparam int LEN_W  = wola_pkg::LEN_W;
	localparam int POS_W  = wola_pkg::POS_W;
	localparam int P1_W   = SAMPLE_BITS + wola_pkg::GAIN_W;
	localparam int PROD_W = P1_W + LEN_W;
	localparam int X_W    = PROD_W + 1;
	localparam int QW     = X_W - 15;
	localparam int CNT_W  = $clog2(QW);
	localparam int SUM_W  = QW + 2;
	localparam int HALF   = FRAME_LENGTH / 2;

	localparam logic signed [SUM_W-1:0] MAXV =
		{{(SUM_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] MINV =
		{{(SUM_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
		return (32'(len) > HALF) ? LEN_W'(HALF) : len;
	endfunction

	// configuration
	logic [LEN_W-1:0]               rise_q;
	logic [LEN_W-1:0]               fall_q;
	logic [wola_pkg::GAIN_W-1:0]    gain_q;
	logic [wola_pkg::MODE_W-1:0]    mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q <= '0;
			fall_q <= '0;
			gain_q <= wola_pkg::GAIN_RESET;
			mode_q <= wola_pkg::MODE_BOTH_RAMPS;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				wola_pkg::REG_RISE_LENGTH: rise_q <= cfg_data[LEN_W-1:0];
				wola_pkg::REG_FALL_LENGTH: fall_q <= cfg_data[LEN_W-1:0];
				wola_pkg::REG_GAIN:        gain_q <= cfg_data[wola_pkg::GAIN_W-1:0];
				wola_pkg::REG_MIX_MODE:    mode_q <= cfg_data[wola_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// segment decode at accept
	logic [LEN_W-1:0]       r_len, f_len, num_c, den_c, fall_num;
	logic [POS_W-1:0]       total, p, seg_i, pos_next;
	logic [POS_W-1:0]       pos_q;
	logic                   in_rise, in_fall, last_c;
	logic [SAMPLE_BITS-1:0] mag_c;

	always_comb begin
		r_len    = clamp_len(rise_q);
		f_len    = clamp_len(fall_q);
		total    = {1'b0, r_len} + {1'b0, f_len};
		p        = restart ? '0 : pos_q;
		in_rise  = p < {1'b0, r_len};
		in_fall  = !in_rise && (p < total);
		seg_i    = p - {1'b0, r_len};
		fall_num = LEN_W'({1'b0, f_len} - seg_i);
		num_c    = '0;
		den_c    = LEN_W'(1);
		if (in_rise) begin
			if (mode_q == wola_pkg::MODE_FLAT_RISE) begin
				num_c = LEN_W'(1);
			end else begin
				num_c = p[LEN_W-1:0];
				den_c = r_len;
			end
		end else if (in_fall) begin
			if (mode_q == wola_pkg::MODE_FLAT_FALL) begin
				num_c = LEN_W'(1);
			end else begin
				num_c = fall_num;
				den_c = f_len;
			end
		end
		last_c   = (total != '0) && (p == total - POS_W'(1));
		pos_next = (p < wola_pkg::POS_MAX) ? p + POS_W'(1) : wola_pkg::POS_MAX;
		// magnitude of the most negative sample still fits unsigned
		mag_c    = grain_sample[SAMPLE_BITS-1] ? (~grain_sample + 1'b1) : grain_sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.accept) begin
			pos_q <= pos_next;
		end
	end

	// item registers
	logic [SAMPLE_BITS-1:0]        mag_q;
	logic                          neg_q, inside_q, last_q;
	logic signed [SAMPLE_BITS-1:0] base_q;
	logic [LEN_W-1:0]              num_q, den_q;
	logic [P1_W-1:0]               p1_q;
	logic [PROD_W-1:0]             prod_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mag_q    <= mag_c;
			neg_q    <= grain_sample[SAMPLE_BITS-1];
			base_q   <= base_sample;
			num_q    <= num_c;
			den_q    <= den_c;
			inside_q <= in_rise || in_fall;
			last_q   <= last_c;
		end
		if (cmd.mul_a) begin
			p1_q <= P1_W'(mag_q) * P1_W'(gain_q);
		end
		if (cmd.mul_b) begin
			prod_q <= PROD_W'(p1_q) * PROD_W'(num_q);
		end
	end

	// restoring divider: quotient = (prod + den*2^14) / 2^15 / den
	logic [X_W-1:0]   x_c;
	logic [LEN_W:0]   trial;
	logic             ge;
	logic [LEN_W-1:0] rem_next;
	logic [QW-1:0]    dvd_q;
	logic [LEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;

	always_comb begin
		x_c      = {1'b0, prod_q} + X_W'({den_q, 14'b0});
		trial    = {rem_q, dvd_q[QW-1]};
		ge       = trial >= {1'b0, den_q};
		rem_next = ge ? LEN_W'(trial - {1'b0, den_q}) : trial[LEN_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dvd_q <= x_c[X_W-1:15];
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[QW-2:0], ge};
			rem_q <= rem_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= CNT_W'(QW - 1);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// sum and saturate
	logic signed [SUM_W-1:0] base_ext, q_ext, sum_c;
	logic [SAMPLE_BITS-1:0]  sat_c;

	always_comb begin
		base_ext = SUM_W'(base_q);
		q_ext    = signed'({2'b00, dvd_q});
		if (!inside_q) begin
			sum_c = base_ext;
		end else if (neg_q) begin
			sum_c = base_ext - q_ext;
		end else begin
			sum_c = base_ext + q_ext;
		end
		if (sum_c > MAXV) begin
			sat_c = MAXV[SAMPLE_BITS-1:0];
		end else if (sum_c < MINV) begin
			sat_c = MINV[SAMPLE_BITS-1:0];
		end else begin
			sat_c = sum_c[SAMPLE_BITS-1:0];
		end
	end

	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] mixed_q;
	logic                   last_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_load) begin
			mixed_q    <= sat_c;
			last_out_q <= last_q;
		end
	end

	assign status.div_done = (cnt_q == '0);
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign mixed_sample    = signed'(mixed_q);
	assign last            = last_out_q;

endmodule

[rtl/core/wola_ctrl.sv]
// sequencer of the mixer: walks each beat through multiply, divide and output
// uses wola_pkg and the assertion macros
`include "windowed_overlap_add_mixer_defines.svh"

module wola_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  wola_pkg::status_t status,
	output wola_pkg::cmd_t    cmd
);

	wola_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wola_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wola_pkg::ST_IDLE: begin
				if (in_valid) state_d = wola_pkg::ST_MUL_A;
			end
			wola_pkg::ST_MUL_A: state_d = wola_pkg::ST_MUL_B;
			wola_pkg::ST_MUL_B: state_d = wola_pkg::ST_LOAD;
			wola_pkg::ST_LOAD:  state_d = wola_pkg::ST_DIV;
			wola_pkg::ST_DIV: begin
				if (status.div_done) state_d = wola_pkg::ST_FIN;
			end
			wola_pkg::ST_FIN: begin
				// wait here while the previous result is still unread
				if (status.out_free) state_d = wola_pkg::ST_IDLE;
			end
			default: state_d = wola_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == wola_pkg::ST_IDLE);
		cmd.accept   = (state_q == wola_pkg::ST_IDLE) && in_valid;
		cmd.mul_a    = (state_q == wola_pkg::ST_MUL_A);
		cmd.mul_b    = (state_q == wola_pkg::ST_MUL_B);
		cmd.load     = (state_q == wola_pkg::ST_LOAD);
		cmd.div_step = (state_q == wola_pkg::ST_DIV);
		cmd.fin_load = (state_q == wola_pkg::ST_FIN) && status.out_free;
	end

	`WOLA_ASSERT(a_accept_starts, clk, arst_n, cmd.accept |=> state_q == wola_pkg::ST_MUL_A)
	`WOLA_ASSERT(a_div_holds, clk, arst_n, (state_q == wola_pkg::ST_DIV && !status.div_done) |=> state_q == wola_pkg::ST_DIV)
	`WOLA_ASSERT(a_fin_returns, clk, arst_n, cmd.fin_load |=> state_q == wola_pkg::ST_IDLE)
	`WOLA_ASSERT_NEVER(a_div_not_instant, clk, arst_n, state_q == wola_pkg::ST_DIV && status.div_done && $past(state_q) == wola_pkg::ST_LOAD)

endmodule

[rtl/core/windowed_overlap_add_mixer.sv]
// Windowed overlap-add mixer, top level.
// Input channel grain_ch carries grain_sample, base_sample and restart; a beat
// moves when valid and ready are high at a rising edge of clk. Each accepted
// beat gives one beat on mix_ch: mixed_sample = base + weighted grain, rounded
// and saturated, and last on sample rise_length + fall_length - 1.
// Configuration: cfg_wr_en, cfg_index (0 rise_length, 1 fall_length, 2 gain,
// 3 mix_mode) and cfg_data, written while no beat is in flight.
// Path from input beat to output valid: two multiply stages, a load state,
// SAMPLE_BITS + 12 steps of a one-bit-per-cycle restoring divider and a
// saturate state. No new beat is taken until the current one is through;
// grain_ch ready is high only while the sequencer is idle.
// Reset (arst_n low) clears the position counter, the sequencer and the output
// valid, and sets rise 0, fall 0, gain 1.0, both-ramps mode.
// A stalled mix_ch holds its beat; the next input beat is still taken, and its
// result waits in the saturate stage until the output register frees.
module windowed_overlap_add_mixer #(
	parameter int FRAME_LENGTH = 1024,
	parameter int SAMPLE_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [wola_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wola_pkg::CFG_DATA_W-1:0] cfg_data,
	wola_in_if.sink                         grain_ch,
	wola_out_if.source                      mix_ch
);

	wola_pkg::cmd_t    cmd;
	wola_pkg::status_t status;

	wola_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (grain_ch.valid),
		.in_ready (grain_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	wola_dp #(
		.FRAME_LENGTH (FRAME_LENGTH),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.grain_sample (grain_ch.grain_sample),
		.base_sample  (grain_ch.base_sample),
		.restart      (grain_ch.restart),
		.cmd          (cmd),
		.status       (status),
		.out_ready    (mix_ch.ready),
		.out_valid    (mix_ch.valid),
		.mixed_sample (mix_ch.mixed_sample),
		.last         (mix_ch.last)
	);

endmodule

[verif/windowed_overlap_add_mixer_tb.sv]
// self-checking bench for the windowed overlap-add mixer: directed and random grains,
// a predictor of the weighted mix and position counter, and a per-field check of every beat
// depends on wola_pkg, the wola_in_if and wola_out_if channels and the mixer rtl
module windowed_overlap_add_mixer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAME_LEN   = 1024;
	localparam int HALF_FRAME  = FRAME_LEN / 2;
	localparam int LONG_HOLD   = 200;
	localparam int END_SETTLE  = 40;
	localparam logic [wola_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

	typedef struct packed {
		logic signed [15:0] grain_sample;
		logic signed [15:0] base_sample;
		logic               restart;
	} grain_beat_t;

	typedef struct packed {
		logic signed [15:0] mixed_sample;
		logic               last;
	} mix_beat_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_wr_en;
	logic [wola_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [wola_pkg::CFG_DATA_W-1:0] cfg_data;

	wola_in_if  #(.SAMPLE_BITS(16)) grain_ch ();
	wola_out_if #(.SAMPLE_BITS(16)) mix_ch ();

	windowed_overlap_add_mixer #(
		.FRAME_LENGTH(FRAME_LEN),
		.SAMPLE_BITS (16)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.grain_ch (grain_ch),
		.mix_ch   (mix_ch)
	);

	// predictor state: register copies and grain position
	logic [wola_pkg::LEN_W-1:0]  rise_q     = '0;
	logic [wola_pkg::LEN_W-1:0]  fall_q     = '0;
	logic [wola_pkg::GAIN_W-1:0] gain_q     = wola_pkg::GAIN_RESET;
	logic [wola_pkg::MODE_W-1:0] mode_q     = wola_pkg::MODE_BOTH_RAMPS;
	logic [wola_pkg::POS_W-1:0]  position_q = '0;

	grain_beat_t grain_queue[$];
	mix_beat_t   mix_expected_q[$];

	int  items_queued = 0;
	int  mixes_seen   = 0;
	int  mismatches   = 0;
	int  settings_used = 0;
	int  send_gap_max = 0;
	int  recv_gap_max = 0;
	int  send_wait    = 0;
	int  recv_wait    = 0;
	logic in_taken    = 1'b0;
	logic out_taken   = 1'b0;
	logic hold_rx     = 1'b0;
	logic long_hold_go = 1'b0;

	always #4 clk = ~clk;

	initial begin
		clk                   = 1'b0;
		arst_n                = 1'b0;
		cfg_wr_en             = 1'b0;
		cfg_index             = '0;
		cfg_data              = '0;
		grain_ch.valid        = 1'b0;
		grain_ch.grain_sample = '0;
		grain_ch.base_sample  = '0;
		grain_ch.restart      = 1'b0;
		mix_ch.ready          = 1'b0;
	end

	function automatic void predict_mix(input logic signed [15:0] grain,
			input logic signed [15:0] base, input logic rs, output mix_beat_t beat);
		longint r, f, total, p, num, den, g, mag, prod, d, q, sum;
		bit in_grain;
		r = (rise_q > HALF_FRAME) ? HALF_FRAME : longint'(rise_q);
		f = (fall_q > HALF_FRAME) ? HALF_FRAME : longint'(fall_q);
		total = r + f;
		if (rs)
			position_q = '0;
		p = longint'(position_q);
		num = 0;
		den = 1;
		in_grain = 1'b0;
		sum = longint'(base);
		if (p < r) begin
			in_grain = 1'b1;
			if (mode_q == wola_pkg::MODE_FLAT_RISE) begin
				num = 1;
				den = 1;
			end else begin
				num = p;
				den = r;
			end
		end else if (p < total) begin
			in_grain = 1'b1;
			if (mode_q == wola_pkg::MODE_FLAT_FALL) begin
				num = 1;
				den = 1;
			end else begin
				num = f - (p - r);
				den = f;
			end
		end
		if (in_grain) begin
			g = longint'(grain);
			mag = (g < 0) ? -g : g;
			prod = mag * longint'(gain_q) * num;
			d = den << 15;
			// round half away from zero on the magnitude
			q = (prod + d / 2) / d;
			sum = (g < 0) ? sum - q : sum + q;
			if (sum > 32767)
				sum = 32767;
			if (sum < -32768)
				sum = -32768;
		end
		beat.mixed_sample = sum[15:0];
		beat.last = (total != 0) && (p == total - 1);
		if (position_q < wola_pkg::POS_MAX)
			position_q = position_q + 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// grain beat driver
	always @(negedge clk) begin : grain_driver
		grain_beat_t nxt;
		if (!arst_n) begin
			grain_ch.valid <= 1'b0;
		end else if (grain_ch.valid && !in_taken) begin
			// beat still on offer
		end else if (send_wait != 0) begin
			grain_ch.valid <= 1'b0;
			if (grain_ch.ready)
				send_wait <= send_wait - 1;
		end else if (grain_queue.size() != 0) begin
			nxt = grain_queue.pop_front();
			grain_ch.grain_sample <= nxt.grain_sample;
			grain_ch.base_sample  <= nxt.base_sample;
			grain_ch.restart      <= nxt.restart;
			grain_ch.valid        <= 1'b1;
			send_wait <= $urandom_range(0, send_gap_max);
		end else begin
			grain_ch.valid <= 1'b0;
		end
	end

	// mix beat receiver; its stall only counts down while a beat is waiting
	always @(negedge clk) begin : mix_receiver
		int n;
		if (!arst_n || hold_rx) begin
			mix_ch.ready <= 1'b0;
		end else if (out_taken) begin
			n = $urandom_range(0, recv_gap_max);
			recv_wait <= n;
			mix_ch.ready <= (n == 0);
		end else if (recv_wait != 0 && mix_ch.valid) begin
			recv_wait <= recv_wait - 1;
			mix_ch.ready <= (recv_wait == 1);
		end else begin
			mix_ch.ready <= (recv_wait == 0);
		end
	end

	initial begin : long_hold
		wait (long_hold_go);
		@(negedge clk);
		hold_rx <= 1'b1;
		repeat (LONG_HOLD) @(negedge clk);
		hold_rx <= 1'b0;
	end

	always @(posedge clk) begin : mix_monitor
		mix_beat_t want;
		in_taken  <= grain_ch.valid && grain_ch.ready;
		out_taken <= mix_ch.valid && mix_ch.ready;
		if (arst_n && grain_ch.valid && grain_ch.ready) begin
			predict_mix(grain_ch.grain_sample, grain_ch.base_sample, grain_ch.restart, want);
			mix_expected_q.push_back(want);
		end
		if (arst_n && mix_ch.valid && mix_ch.ready) begin
			if (mix_expected_q.size() == 0) begin
				report_mismatch($sformatf("mix beat %0d with nothing pending",
					mix_ch.mixed_sample));
			end else begin
				want = mix_expected_q.pop_front();
				if (mix_ch.mixed_sample !== want.mixed_sample)
					report_mismatch($sformatf("beat %0d mixed_sample %0d, want %0d",
						mixes_seen, mix_ch.mixed_sample, want.mixed_sample));
				if (mix_ch.last !== want.last)
					report_mismatch($sformatf("beat %0d last %0b, want %0b",
						mixes_seen, mix_ch.last, want.last));
				mixes_seen++;
			end
		end
	end

	task automatic push_item(input logic signed [15:0] grain, input logic signed [15:0] base,
			input logic rs);
		grain_beat_t b;
		b.grain_sample = grain;
		b.base_sample  = base;
		b.restart      = rs;
		grain_queue.push_back(b);
		items_queued++;
	endtask

	// every beat sent has come back
	task automatic drain();
		while (mixes_seen != items_queued)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [wola_pkg::CFG_IDX_W-1:0] idx,
			input logic [wola_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			wola_pkg::REG_RISE_LENGTH: rise_q = data[wola_pkg::LEN_W-1:0];
			wola_pkg::REG_FALL_LENGTH: fall_q = data[wola_pkg::LEN_W-1:0];
			wola_pkg::REG_GAIN:        gain_q = data[wola_pkg::GAIN_W-1:0];
			wola_pkg::REG_MIX_MODE:    mode_q = data[wola_pkg::MODE_W-1:0];
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// unused upper data bits are randomised, the block must ignore them
	task automatic set_mix(input int rise, input int fall,
			input logic [wola_pkg::GAIN_W-1:0] g, input logic [wola_pkg::MODE_W-1:0] mode);
		write_reg(wola_pkg::REG_RISE_LENGTH, {6'($urandom), 10'(rise)});
		write_reg(wola_pkg::REG_FALL_LENGTH, {6'($urandom), 10'(fall)});
		write_reg(wola_pkg::REG_GAIN, g);
		write_reg(wola_pkg::REG_MIX_MODE, {14'($urandom), mode});
		settings_used++;
	endtask

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return 16'($urandom_range(0, 8) - 4);
			default: return 16'($urandom);
		endcase
	endfunction

	// six beats over a three plus three grain, flat segments in the modes under test
	task automatic push_flat_probe();
		push_item(16'sd1000, 16'sd0, 1'b1);
		push_item(-16'sd1000, 16'sd0, 1'b0);
		push_item(16'sd1, 16'sd0, 1'b0);
		push_item(-16'sd1, 16'sd0, 1'b0);
		push_item(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
		push_item(16'sd3, 16'sd3, 1'b0);
	endtask

	task automatic random_phase(input int n_items, input int max_len, input bit pause_mid,
			input bit with_hold);
		int rise, fall, total, len, k;
		logic [wola_pkg::GAIN_W-1:0] g;
		logic rs;
		rise = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, max_len);
		fall = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, max_len);
		case ($urandom_range(0, 4))
			0: g = '0;
			1: g = '1;
			2: g = wola_pkg::GAIN_RESET;
			default: g = wola_pkg::GAIN_W'($urandom);
		endcase
		drain();
		set_mix(rise, fall, g, wola_pkg::MODE_W'($urandom_range(0, 3)));
		total = rise + fall;
		k = 0;
		while (k < n_items) begin
			len = total + $urandom_range(0, 2);
			// broken grain: cut short by the next restart
			if ($urandom_range(0, 7) == 0)
				len = $urandom_range(1, total + 1);
			if (len == 0)
				len = 1;
			for (int j = 0; j < len && k < n_items; j++) begin
				if (j == 0)
					rs = ($urandom_range(0, 7) != 0);
				else
					rs = ($urandom_range(0, 31) == 0);
				push_item(rand_sample(), rand_sample(), rs);
				k++;
				if (pause_mid && k == n_items / 2)
					drain();
			end
		end
		if (with_hold)
			long_hold_go = 1'b1;
	endtask

	initial begin : stimulus
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings give an empty grain: base passes through
		push_item(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
		push_item(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
		drain();

		// both ramps at full gain: zero weight, saturation both ways, rounding, grain end
		set_mix(3, 3, '1, wola_pkg::MODE_BOTH_RAMPS);
		push_item(SAMPLE_MIN, SAMPLE_MIN, 1'b1);
		push_item(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
		push_item(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
		push_item(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
		push_item(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
		push_item(-16'sd1, 16'sd0, 1'b0);
		push_item(SAMPLE_MAX, 16'sd5, 1'b0);
		push_item(SAMPLE_MIN, -16'sd5, 1'b0);
		drain();
		set_mix(3, 3, wola_pkg::GAIN_RESET, wola_pkg::MODE_FLAT_RISE);
		push_flat_probe();
		drain();
		set_mix(3, 3, wola_pkg::GAIN_RESET, wola_pkg::MODE_FLAT_FALL);
		push_flat_probe();
		drain();
		set_mix(2, 1, wola_pkg::GAIN_RESET, MODE_UNUSED);
		push_item(16'sd1000, 16'sd0, 1'b1);
		push_item(16'sd1000, 16'sd0, 1'b0);
		push_item(16'sd1000, 16'sd0, 1'b0);

		for (int ph = 0; ph < 8; ph++) begin
			send_gap_max = (ph == 0 || ph == 5) ? 0 : 10;
			recv_gap_max = (ph == 0 || ph == 6) ? 0 : 10;
			random_phase(50, (ph < 2) ? 2 : 12, ph == 4, ph == 2);
		end

		// over-long lengths: each ramp divides by the clamped half frame
		drain();
		send_gap_max = 0;
		recv_gap_max = 0;
		set_mix(1023, 0, wola_pkg::GAIN_W'($urandom), wola_pkg::MODE_BOTH_RAMPS);
		for (int j = 0; j < 20; j++)
			push_item(rand_sample(), rand_sample(), j == 0);
		drain();
		set_mix(0, 513, '1, wola_pkg::MODE_BOTH_RAMPS);
		for (int j = 0; j < 20; j++)
			push_item(rand_sample(), rand_sample(), j == 0);

		send_gap_max = 10;
		recv_gap_max = 10;
		random_phase(50, 12, 1'b0, 1'b0);
		random_phase(50, 6, 1'b0, 1'b0);

		drain();
		repeat (END_SETTLE) @(posedge clk);
		$display("covered %0d grain beats over %0d register settings, %0d mix beats checked",
			items_queued, settings_used, mixes_seen);
		$display("clamped lengths, all four modes, early restarts and a long output stall seen");
		if (mismatches == 0)
			$display("windowed_overlap_add_mixer regression: pass");
		else
			$display("windowed_overlap_add_mixer regression: fail");
		$finish;
	end

	initial begin : watchdog
		#8ms;
		$display("timed out with %0d of %0d mix beats seen", mixes_seen, items_queued);
		$display("windowed_overlap_add_mixer regression: fail");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/wola_pkg.sv
rtl/core/wola_in_if.sv
rtl/core/wola_out_if.sv
rtl/core/wola_dp.sv
rtl/core/wola_ctrl.sv
rtl/core/windowed_overlap_add_mixer.sv
verif/windowed_overlap_add_mixer_tb.sv
